### sv/tlsr_pkg.sv
// ----------------------------------------------------------------------------
// tlsr_pkg
// Shared constants and types of the two-level segmenter: field widths,
// header codes, register indexes, status codes and the front phase type.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsr_pkg;

  // Default geometry
  localparam int SEGMENT_PAYLOAD_DEF = 726;
  localparam int FRAME_PAYLOAD_DEF   = 30;

  // Segment and frame header sizes
  localparam int SEG_HDR_LEN = 4;
  localparam int FRM_HDR_LEN = 4;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int DATA_LEN_W = 18;
  localparam int STATUS_W   = 2;
  localparam int IN_TDATA_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = DATA_LEN_W;

  // Register reset values
  localparam logic [DATA_LEN_W-1:0] DATA_LENGTH_RST = 18'd76800;
  localparam logic [BYTE_W-1:0]     KIND_BYTE_RST   = 8'h00;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DATA_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KIND_BYTE   = 2'd1;

  // Frame header bytes
  localparam logic [BYTE_W-1:0] FRM_SYNC = 8'h02;
  localparam logic [BYTE_W-1:0] FRM_ZERO = 8'h00;

  // Item kinds
  localparam logic FUNC_DATA   = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  // Receiver status codes
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACK    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BACK   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REPEAT = 2'd3;

  // Depth of the frame request queue
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic {
    PH_FILL = 1'b0,
    PH_SEND = 1'b1
  } phase_t;

  // Flow status seen by the front
  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic back_idle;
  } flow_t;

endpackage

`default_nettype wire

### sv/tlsr_cmd_queue.sv
// ----------------------------------------------------------------------------
// tlsr_cmd_queue
// Short FIFO of frame requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_cmd_queue import tlsr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### sv/tlsr_front.sv
// ----------------------------------------------------------------------------
// tlsr_front
// Accepts data bytes and receiver status, fills the segment store, tracks
// segment and frame position and queues one request per frame to send.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_front import tlsr_pkg::*; #(
  parameter int SEGMENT_PAYLOAD = SEGMENT_PAYLOAD_DEF,
  parameter int FRAME_PAYLOAD   = FRAME_PAYLOAD_DEF,
  localparam int PADDED_LEN  = SEGMENT_PAYLOAD + SEG_HDR_LEN,
  localparam int FRAME_COUNT = (PADDED_LEN + FRAME_PAYLOAD - 1) / FRAME_PAYLOAD,
  localparam int FN_W        = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  localparam int SL_W        = $clog2(SEGMENT_PAYLOAD + 1),
  localparam int AW          = $clog2(SEGMENT_PAYLOAD),
  localparam int CMD_W       = SL_W + BYTE_W + FN_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire flow_t                 flow,
  output logic                       cmd_push,
  output logic      [CMD_W-1:0]      cmd_data,
  output logic                       wr_en,
  output logic      [AW-1:0]         wr_addr,
  output logic      [BYTE_W-1:0]     wr_data,
  output logic      [BYTE_W-1:0]     kind_byte
);

  phase_t                phase_r, phase_nxt;
  logic [DATA_LEN_W-1:0] data_length_r, data_length_nxt;
  logic [BYTE_W-1:0]     kind_r, kind_nxt;
  logic [SL_W-1:0]       fill_r, fill_nxt;
  logic [BYTE_W-1:0]     seg_num_r, seg_num_nxt;
  logic [FN_W-1:0]       frame_r, frame_nxt;
  logic [DATA_LEN_W-1:0] consumed_r, consumed_nxt;
  logic [DATA_LEN_W-1:0] seg_start_r, seg_start_nxt;

  logic [DATA_LEN_W-1:0] total;
  logic [DATA_LEN_W-1:0] rem;
  logic [SL_W-1:0]       seg_len;
  logic [SL_W:0]         fill_inc;
  logic [FN_W:0]         frame_inc;
  logic                  seg_done, last_frame;
  logic                  accept, is_data;
  logic [BYTE_W-1:0]     in_byte;
  logic [STATUS_W-1:0]   in_status;
  logic                  ev_store, ev_ack, ev_back, ev_rep;
  logic                  restart;

  assign in_byte   = in_tdata[BYTE_W-1:0];
  assign in_status = in_tdata[BYTE_W +: STATUS_W];
  assign is_data   = (in_tuser == FUNC_DATA);

  // Data may only land in the store once the back has read out the old segment
  assign in_tready = !flow.q_full &&
                     ((phase_r == PH_SEND) || (flow.back_idle && flow.q_empty));
  assign accept    = in_tvalid && in_tready;

  // Current segment length: min(payload, bytes left in the image)
  assign total   = (data_length_r == '0) ? DATA_LEN_W'(1) : data_length_r;
  assign rem     = (total > seg_start_r) ? (total - seg_start_r) : '0;
  assign seg_len = (rem < DATA_LEN_W'(SEGMENT_PAYLOAD)) ? rem[SL_W-1:0]
                                                        : SL_W'(SEGMENT_PAYLOAD);

  assign fill_inc   = {1'b0, fill_r} + 1'b1;
  assign seg_done   = (fill_inc >= {1'b0, seg_len});
  assign frame_inc  = {1'b0, frame_r} + 1'b1;
  assign last_frame = (frame_inc >= (FN_W + 1)'(FRAME_COUNT));

  assign restart  = cfg_we && (cfg_addr == CFG_DATA_LENGTH);
  assign ev_store = accept && is_data && (phase_r == PH_FILL);
  assign ev_ack   = accept && !is_data && (phase_r == PH_SEND) && (in_status == ST_ACK);
  assign ev_back  = accept && !is_data && (phase_r == PH_SEND) && (in_status == ST_BACK);
  assign ev_rep   = accept && !is_data && (phase_r == PH_SEND) && (in_status == ST_REPEAT);

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    data_length_nxt = data_length_r;
    kind_nxt        = kind_r;
    fill_nxt        = fill_r;
    seg_num_nxt     = seg_num_r;
    frame_nxt       = frame_r;
    consumed_nxt    = consumed_r;
    seg_start_nxt   = seg_start_r;
    if (cfg_we && (cfg_addr == CFG_KIND_BYTE)) begin
      kind_nxt = cfg_wdata[BYTE_W-1:0];
    end
    if (restart) begin
      // abandon the current image
      data_length_nxt = cfg_wdata[DATA_LEN_W-1:0];
      phase_nxt       = PH_FILL;
      fill_nxt        = '0;
      seg_num_nxt     = '0;
      frame_nxt       = '0;
      consumed_nxt    = '0;
      seg_start_nxt   = '0;
    end else if (ev_store) begin
      fill_nxt     = fill_inc[SL_W-1:0];
      consumed_nxt = consumed_r + 1'b1;
      if (seg_done) begin
        phase_nxt = PH_SEND;
        frame_nxt = '0;
      end
    end else if (ev_ack) begin
      if (last_frame) begin
        phase_nxt = PH_FILL;
        frame_nxt = '0;
        fill_nxt  = '0;
        if (consumed_r >= total) begin
          consumed_nxt  = '0;
          seg_num_nxt   = '0;
          seg_start_nxt = '0;
        end else begin
          seg_num_nxt   = seg_num_r + 1'b1;
          seg_start_nxt = consumed_r;
        end
      end else begin
        frame_nxt = frame_inc[FN_W-1:0];
      end
    end else if (ev_back) begin
      if (frame_r != '0) begin
        frame_nxt = frame_r - 1'b1;
      end
    end
  end

  // Outputs
  always_comb begin
    wr_en     = ev_store;
    wr_addr   = fill_r[AW-1:0];
    wr_data   = in_byte;
    kind_byte = kind_r;
    cmd_push  = !restart &&
                ((ev_store && seg_done) || (ev_ack && !last_frame) || ev_back || ev_rep);
    cmd_data  = {seg_len, seg_num_r, frame_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_FILL;
      data_length_r <= DATA_LENGTH_RST;
      kind_r        <= KIND_BYTE_RST;
      fill_r        <= '0;
      seg_num_r     <= '0;
      frame_r       <= '0;
      consumed_r    <= '0;
      seg_start_r   <= '0;
    end else begin
      phase_r       <= phase_nxt;
      data_length_r <= data_length_nxt;
      kind_r        <= kind_nxt;
      fill_r        <= fill_nxt;
      seg_num_r     <= seg_num_nxt;
      frame_r       <= frame_nxt;
      consumed_r    <= consumed_nxt;
      seg_start_r   <= seg_start_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !flow.q_full)
    else $error("frame request pushed into a full queue");

  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FILL) |-> (fill_r < seg_len))
    else $error("fill count reached segment length while filling");

  a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, frame_r} < (FN_W + 1)'(FRAME_COUNT)))
    else $error("frame number beyond frame count");
`endif

endmodule

`default_nettype wire

### sv/tlsr_back.sv
// ----------------------------------------------------------------------------
// tlsr_back
// Holds the segment store and turns each queued frame request into the
// frame's bytes, one byte per cycle while out_tready is high, through a
// read stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_back import tlsr_pkg::*; #(
  parameter int SEGMENT_PAYLOAD = SEGMENT_PAYLOAD_DEF,
  parameter int FRAME_PAYLOAD   = FRAME_PAYLOAD_DEF,
  localparam int PADDED_LEN  = SEGMENT_PAYLOAD + SEG_HDR_LEN,
  localparam int FRAME_COUNT = (PADDED_LEN + FRAME_PAYLOAD - 1) / FRAME_PAYLOAD,
  localparam int FN_W        = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  localparam int SL_W        = $clog2(SEGMENT_PAYLOAD + 1),
  localparam int AW          = $clog2(SEGMENT_PAYLOAD),
  localparam int CMD_W       = SL_W + BYTE_W + FN_W,
  localparam int FRAME_LEN   = FRAME_PAYLOAD + FRM_HDR_LEN,
  localparam int CNT_W       = $clog2(FRAME_LEN),
  localparam int POS_W       = $clog2(FRAME_COUNT * FRAME_PAYLOAD + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic [BYTE_W-1:0] kind_byte,
  input  wire logic [CMD_W-1:0]  cmd_data,
  input  wire logic              cmd_empty,
  output logic                   cmd_pop,
  output logic                   back_idle,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [BYTE_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic [BYTE_W-1:0] mem [SEGMENT_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FN_W-1:0]   frame_r;
  logic [BYTE_W-1:0] seg_num_r;
  logic [SL_W-1:0]   seg_len_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mem_r, s1_last_r;
  logic [BYTE_W-1:0] s1_byte_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              out_free, issue, load, mem_rd, last_byte;
  logic [FN_W-1:0]   cmd_frame;
  logic [BYTE_W-1:0] cmd_seg_num;
  logic [SL_W-1:0]   cmd_seg_len;
  logic [POS_W-1:0]  start;
  logic [POS_W:0]    plen_rem;
  logic [BYTE_W-1:0] plen;
  logic [FN_W+BYTE_W-1:0] frame_ext;
  logic [SL_W+2*BYTE_W-1:0] len_ext;
  logic [POS_W-1:0]  seg_pos;
  logic              in_seg;
  logic [BYTE_W-1:0] sel_byte;

  assign {cmd_seg_len, cmd_seg_num, cmd_frame} = cmd_data;

  assign out_free  = !out_valid_r || out_tready;
  assign load      = !busy_r && !cmd_empty;
  assign issue     = busy_r && (!s1_valid_r || out_free);
  assign last_byte = (cnt_r == CNT_W'(FRAME_LEN - 1));
  assign cmd_pop   = load;
  assign back_idle = !busy_r;

  assign start     = POS_W'(cmd_frame) * POS_W'(FRAME_PAYLOAD);

  // Frame payload length: min(frame payload, bytes left in the padded segment)
  assign plen_rem  = (POS_W + 1)'(PADDED_LEN) - {1'b0, pos_r};
  assign plen      = (plen_rem < (POS_W + 1)'(FRAME_PAYLOAD)) ? BYTE_W'(plen_rem)
                                                             : BYTE_W'(FRAME_PAYLOAD);
  assign frame_ext = {{BYTE_W{1'b0}}, frame_r};
  assign len_ext   = {{(2 * BYTE_W){1'b0}}, seg_len_r};

  assign seg_pos   = pos_r - POS_W'(SEG_HDR_LEN);
  assign in_seg    = ({1'b0, pos_r} >= (POS_W + 1)'(SEG_HDR_LEN)) &&
                     ({1'b0, pos_r} < (POS_W + 1)'(PADDED_LEN)) &&
                     ({1'b0, seg_pos} < (POS_W + 1)'(seg_len_r));
  assign mem_rd    = issue && (cnt_r >= CNT_W'(FRM_HDR_LEN)) && in_seg;

  // Byte for the current count; store bytes come through rd_data_r
  always_comb begin
    sel_byte = '0;
    if (cnt_r == CNT_W'(0)) begin
      sel_byte = FRM_SYNC;
    end else if (cnt_r == CNT_W'(1)) begin
      sel_byte = FRM_ZERO;
    end else if (cnt_r == CNT_W'(2)) begin
      sel_byte = plen;
    end else if (cnt_r == CNT_W'(3)) begin
      sel_byte = frame_ext[BYTE_W-1:0];
    end else if (pos_r == POS_W'(0)) begin
      sel_byte = kind_byte;
    end else if (pos_r == POS_W'(1)) begin
      sel_byte = seg_num_r;
    end else if (pos_r == POS_W'(2)) begin
      sel_byte = len_ext[2*BYTE_W-1:BYTE_W];
    end else if (pos_r == POS_W'(3)) begin
      sel_byte = len_ext[BYTE_W-1:0];
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      pos_nxt  = start;
    end else if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
      // advance the segment position once the frame header is out
      if (cnt_r >= CNT_W'(FRM_HDR_LEN)) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (last_byte) begin
        busy_nxt = 1'b0;
      end
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_valid_r && out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    if (load) begin
      frame_r   <= cmd_frame;
      seg_num_r <= cmd_seg_num;
      seg_len_r <= cmd_seg_len;
    end
    if (issue) begin
      s1_mem_r  <= mem_rd;
      s1_byte_r <= sel_byte;
      s1_last_r <= last_byte;
    end
    if (out_free && s1_valid_r) begin
      out_byte_r <= s1_mem_r ? rd_data_r : s1_byte_r;
      out_last_r <= s1_last_r;
    end
  end

  // Segment store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_rd) begin
      rd_data_r <= mem[seg_pos[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last_byte) |=> !busy_r)
    else $error("back still busy after the last frame byte");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!busy_r && cmd_empty))
    else $error("segment store written while a frame is read out");
`endif

endmodule

`default_nettype wire

### sv/two_level_segmenter_with_retransmit.sv
// ----------------------------------------------------------------------------
// two_level_segmenter_with_retransmit
// Cuts an image byte stream into headed segments and sends each segment as
// fixed-size link frames, driven by receiver status.
// ----------------------------------------------------------------------------
// Input channel (in_*): in_tuser selects the item kind, 0 for an image byte
// in in_tdata[7:0], 1 for a receiver status in in_tdata[9:8]. Output channel
// (out_*): one frame byte per transfer, out_tlast on the last byte of each
// frame. cfg_we/cfg_addr/cfg_wdata write data_length (index 0) and kind_byte
// (index 1); writing data_length restarts the image.
// The byte that completes a segment causes frame 0; every back or repeat
// status during sending, and every ack but the one for the last frame,
// causes one frame of FRAME_PAYLOAD + 4 bytes. A taken request is loaded,
// then each byte passes the read stage and the output register, one byte
// per cycle while out_tready is high; a queued request is loaded only once
// the back is idle after a frame's last byte. Up to two frame requests
// queue between front and back. A stall on out_tready holds the output
// register and, once the queue fills, in_tready drops. Image bytes are
// stored only while filling, and then taken only when the back is idle with
// an empty queue, so the store is never overwritten while read. Reset returns
// to filling with data_length 76800, kind_byte 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_segmenter_with_retransmit import tlsr_pkg::*; #(
  parameter int SEGMENT_PAYLOAD = SEGMENT_PAYLOAD_DEF,
  parameter int FRAME_PAYLOAD   = FRAME_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // data_byte[7:0], link_status[9:8]
  input  wire logic                  in_tuser,   // func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [BYTE_W-1:0]     out_tdata,  // frame_byte[7:0]
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PADDED_LEN  = SEGMENT_PAYLOAD + SEG_HDR_LEN;
  localparam int FRAME_COUNT = (PADDED_LEN + FRAME_PAYLOAD - 1) / FRAME_PAYLOAD;
  localparam int FN_W        = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int SL_W        = $clog2(SEGMENT_PAYLOAD + 1);
  localparam int AW          = $clog2(SEGMENT_PAYLOAD);
  localparam int CMD_W       = SL_W + BYTE_W + FN_W;

  flow_t             flow;
  logic              cmd_push, cmd_pop, q_full, q_empty, back_idle;
  logic [CMD_W-1:0]  cmd_wdata, cmd_rdata;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] kind_byte;

  assign flow.q_full    = q_full;
  assign flow.q_empty   = q_empty;
  assign flow.back_idle = back_idle;

  tlsr_front #(
    .SEGMENT_PAYLOAD (SEGMENT_PAYLOAD),
    .FRAME_PAYLOAD   (FRAME_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .flow      (flow),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .kind_byte (kind_byte)
  );

  tlsr_cmd_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  tlsr_back #(
    .SEGMENT_PAYLOAD (SEGMENT_PAYLOAD),
    .FRAME_PAYLOAD   (FRAME_PAYLOAD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .kind_byte  (kind_byte),
    .cmd_data   (cmd_rdata),
    .cmd_empty  (q_empty),
    .cmd_pop    (cmd_pop),
    .back_idle  (back_idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
